@@ rtl/hight_pkg.sv @@
// ----------------------------------------------------------------------------
// HIGHT package
// Shared types, the delta table, the key schedule and the round functions
// of the HIGHT 64-bit block cipher with a 128-bit master key.
// ----------------------------------------------------------------------------
package hight_pkg;

    typedef logic [7:0]   byte_t;
    typedef logic [63:0]  block_t;
    typedef logic [127:0] mkey_t;
    typedef logic [31:0]  skword_t;

    // Operation carried with each item.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Configuration register indexes.
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Number of round stages between the input and output transforms.
    localparam int unsigned ROUND_STAGES = 31;

    // Delta bytes produced by the 7-bit LFSR seeded with 0x5A.
    localparam byte_t DELTA [128] = '{
        8'h5A, 8'h6D, 8'h36, 8'h1B, 8'h0D, 8'h06, 8'h03, 8'h41,
        8'h60, 8'h30, 8'h18, 8'h4C, 8'h66, 8'h33, 8'h59, 8'h2C,
        8'h56, 8'h2B, 8'h15, 8'h4A, 8'h65, 8'h72, 8'h39, 8'h1C,
        8'h4E, 8'h67, 8'h73, 8'h79, 8'h3C, 8'h5E, 8'h6F, 8'h37,
        8'h5B, 8'h2D, 8'h16, 8'h0B, 8'h05, 8'h42, 8'h21, 8'h50,
        8'h28, 8'h54, 8'h2A, 8'h55, 8'h6A, 8'h75, 8'h7A, 8'h7D,
        8'h3E, 8'h5F, 8'h2F, 8'h17, 8'h4B, 8'h25, 8'h52, 8'h29,
        8'h14, 8'h0A, 8'h45, 8'h62, 8'h31, 8'h58, 8'h6C, 8'h76,
        8'h3B, 8'h1D, 8'h0E, 8'h47, 8'h63, 8'h71, 8'h78, 8'h7C,
        8'h7E, 8'h7F, 8'h3F, 8'h1F, 8'h0F, 8'h07, 8'h43, 8'h61,
        8'h70, 8'h38, 8'h5C, 8'h6E, 8'h77, 8'h7B, 8'h3D, 8'h1E,
        8'h4F, 8'h27, 8'h53, 8'h69, 8'h34, 8'h1A, 8'h4D, 8'h26,
        8'h13, 8'h49, 8'h24, 8'h12, 8'h09, 8'h04, 8'h02, 8'h01,
        8'h40, 8'h20, 8'h10, 8'h08, 8'h44, 8'h22, 8'h11, 8'h48,
        8'h64, 8'h32, 8'h19, 8'h0C, 8'h46, 8'h23, 8'h51, 8'h68,
        8'h74, 8'h3A, 8'h5D, 8'h2E, 8'h57, 8'h6B, 8'h35, 8'h5A
    };

    function automatic byte_t rol8(input byte_t x, input int unsigned n);
        return byte_t'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic byte_t f0(input byte_t x);
        return rol8(x, 1) ^ rol8(x, 2) ^ rol8(x, 7);
    endfunction

    function automatic byte_t f1(input byte_t x);
        return rol8(x, 3) ^ rol8(x, 4) ^ rol8(x, 6);
    endfunction

    // Subkey k: key byte ((j - i) mod 8) of the selected half plus delta k,
    // where i is k / 16 and j is k mod 8.
    function automatic byte_t subkey(input mkey_t mk, input logic [6:0] k);
        logic [3:0] m;
        m = {k[3], 3'(k[2:0] - k[6:4])};
        return byte_t'(mk[{m, 3'b000} +: 8] + DELTA[k]);
    endfunction

    // Four consecutive subkeys starting at base, the lowest in the low byte.
    function automatic skword_t subkey_word(input mkey_t mk, input logic [6:0] base);
        return {subkey(mk, 7'(base + 7'd3)), subkey(mk, 7'(base + 7'd2)),
                subkey(mk, 7'(base + 7'd1)), subkey(mk, base)};
    endfunction

    // Whitening key i: bytes 12..15 of the key for i below four, else 0..3.
    function automatic byte_t wkey(input mkey_t mk, input logic [2:0] i);
        logic [3:0] m;
        m = {~i[2], ~i[2], i[1:0]};
        return mk[{m, 3'b000} +: 8];
    endfunction

    // Input transform: whitening for encryption; for decryption the inverse
    // of the output whitening and of the last (unswapped) round.
    function automatic block_t input_xform(input logic mode, input block_t blk,
                                           input mkey_t mk, input skword_t skl);
        byte_t x [8];
        block_t res;
        for (int i = 0; i < 8; i++) begin
            x[i] = blk[8*i +: 8];
        end
        if (mode == MODE_DEC) begin
            x[0] = byte_t'(x[0] - wkey(mk, 3'd4));
            x[2] = x[2] ^ wkey(mk, 3'd5);
            x[4] = byte_t'(x[4] - wkey(mk, 3'd6));
            x[6] = x[6] ^ wkey(mk, 3'd7);
            x[1] = byte_t'(x[1] - (f1(x[0]) ^ skl[7:0]));
            x[3] = x[3] ^ byte_t'(f0(x[2]) + skl[15:8]);
            x[5] = byte_t'(x[5] - (f1(x[4]) ^ skl[23:16]));
            x[7] = x[7] ^ byte_t'(f0(x[6]) + skl[31:24]);
        end else begin
            x[0] = byte_t'(x[0] + wkey(mk, 3'd0));
            x[2] = x[2] ^ wkey(mk, 3'd1);
            x[4] = byte_t'(x[4] + wkey(mk, 3'd2));
            x[6] = x[6] ^ wkey(mk, 3'd3);
        end
        for (int i = 0; i < 8; i++) begin
            res[8*i +: 8] = x[i];
        end
        return res;
    endfunction

    // Output transform: last round plus whitening for encryption; inverse
    // input whitening for decryption.
    function automatic block_t output_xform(input logic mode, input block_t blk,
                                            input mkey_t mk, input skword_t skl);
        byte_t x [8];
        block_t res;
        for (int i = 0; i < 8; i++) begin
            x[i] = blk[8*i +: 8];
        end
        if (mode == MODE_DEC) begin
            x[0] = byte_t'(x[0] - wkey(mk, 3'd0));
            x[2] = x[2] ^ wkey(mk, 3'd1);
            x[4] = byte_t'(x[4] - wkey(mk, 3'd2));
            x[6] = x[6] ^ wkey(mk, 3'd3);
        end else begin
            x[1] = byte_t'(x[1] + (f1(x[0]) ^ skl[7:0]));
            x[3] = x[3] ^ byte_t'(f0(x[2]) + skl[15:8]);
            x[5] = byte_t'(x[5] + (f1(x[4]) ^ skl[23:16]));
            x[7] = x[7] ^ byte_t'(f0(x[6]) + skl[31:24]);
            x[0] = byte_t'(x[0] + wkey(mk, 3'd4));
            x[2] = x[2] ^ wkey(mk, 3'd5);
            x[4] = byte_t'(x[4] + wkey(mk, 3'd6));
            x[6] = x[6] ^ wkey(mk, 3'd7);
        end
        for (int i = 0; i < 8; i++) begin
            res[8*i +: 8] = x[i];
        end
        return res;
    endfunction

endpackage

@@ rtl/hight_round.sv @@
// ----------------------------------------------------------------------------
// HIGHT round
// One swapping round, forward for encryption or inverse for decryption,
// with its four subkey bytes supplied by the caller.
// ----------------------------------------------------------------------------
module hight_round (
    input  logic               mode,
    input  hight_pkg::block_t  block_in,
    input  hight_pkg::skword_t sk,
    output hight_pkg::block_t  block_out
);

    hight_pkg::byte_t x [8];
    hight_pkg::byte_t y [8];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            x[i] = block_in[8*i +: 8];
        end
        if (mode == hight_pkg::MODE_DEC) begin
            y[0] = x[1];
            y[2] = x[3];
            y[4] = x[5];
            y[6] = x[7];
            y[7] = x[0] ^ hight_pkg::byte_t'(hight_pkg::f0(x[7]) + sk[31:24]);
            y[1] = hight_pkg::byte_t'(x[2] - (hight_pkg::f1(x[1]) ^ sk[7:0]));
            y[3] = x[4] ^ hight_pkg::byte_t'(hight_pkg::f0(x[3]) + sk[15:8]);
            y[5] = hight_pkg::byte_t'(x[6] - (hight_pkg::f1(x[5]) ^ sk[23:16]));
        end else begin
            y[1] = x[0];
            y[3] = x[2];
            y[5] = x[4];
            y[7] = x[6];
            y[0] = x[7] ^ hight_pkg::byte_t'(hight_pkg::f0(x[6]) + sk[31:24]);
            y[2] = hight_pkg::byte_t'(x[1] + (hight_pkg::f1(x[0]) ^ sk[7:0]));
            y[4] = x[3] ^ hight_pkg::byte_t'(hight_pkg::f0(x[2]) + sk[15:8]);
            y[6] = hight_pkg::byte_t'(x[5] + (hight_pkg::f1(x[4]) ^ sk[23:16]));
        end
        for (int i = 0; i < 8; i++) begin
            block_out[8*i +: 8] = y[i];
        end
    end

endmodule

@@ rtl/hight_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output skid slot is empty.
// 33 register stages: the input transform, one stage per swapping
// round, and the output register, which takes the last round and the
// output whitening.
// Reset (aresetn low at a clock edge) clears both key registers to zero and
// empties the pipeline and the output buffer.
// ----------------------------------------------------------------------------
// HIGHT block cipher top level
// Pipelined HIGHT-64/128 encrypt and decrypt engine with a stream interface.
// ----------------------------------------------------------------------------
module hight_block_cipher_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,

    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] block_in
    input  logic        s_tuser,    // [0] mode: 0 encrypt, 1 decrypt

    // Result item stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // [63:0] block_out
);

    // Stage 0 holds the input transform, stages 1 to 31 one round each.
    localparam int unsigned STAGES = hight_pkg::ROUND_STAGES + 1;

    // Master key. The user must write both halves only while the pipeline is
    // empty (the block does not enforce this), so every stage may read the key and derive its subkeys directly.
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    hight_pkg::mkey_t mk;

    assign mk = {key_high_reg, key_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hight_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                hight_pkg::REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The last four subkeys serve both the encrypt output transform and the
    // decrypt input transform.
    hight_pkg::skword_t sk_last;
    assign sk_last = hight_pkg::subkey_word(mk, 7'd124);

    // Pipeline. The whole pipeline moves together whenever the output skid
    // slot is free; the output register plus the skid slot let the pipeline
    // keep accepting while a finished item waits on m_tready and the skid slot is empty.
    logic                pipe_en;
    logic [STAGES-1:0]   valid_reg;
    logic                mode_reg [STAGES];
    hight_pkg::block_t   data_reg [STAGES];
    hight_pkg::block_t   data_next [STAGES];

    assign s_tready = pipe_en;

    assign data_next[0] = hight_pkg::input_xform(s_tuser, s_tdata, mk, sk_last);

    for (genvar t = 1; t < STAGES; t++) begin : g_round
        // Encryption runs rounds upward, decryption runs them downward.
        localparam logic [6:0] ENC_BASE = 7'(4 * (t - 1));
        localparam logic [6:0] DEC_BASE = 7'(4 * (STAGES - 1 - t));

        hight_pkg::skword_t sk;

        assign sk = (mode_reg[t-1] == hight_pkg::MODE_DEC)
                  ? hight_pkg::subkey_word(mk, DEC_BASE)
                  : hight_pkg::subkey_word(mk, ENC_BASE);

        hight_round u_round (
            .mode      (mode_reg[t-1]),
            .block_in  (data_reg[t-1]),
            .sk        (sk),
            .block_out (data_next[t])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mode_reg[0] <= s_tuser;
            data_reg[0] <= data_next[0];
            for (int s = 1; s < STAGES; s++) begin
                mode_reg[s] <= mode_reg[s-1];
                data_reg[s] <= data_next[s];
            end
        end
    end

    // Output transform of the item leaving the last stage.
    hight_pkg::block_t out_data;
    assign out_data = hight_pkg::output_xform(mode_reg[STAGES-1], data_reg[STAGES-1],
                                              mk, sk_last);

    // Output register and one skid slot. An item leaves the pipeline only
    // while the skid slot is empty, so it always finds a place.
    logic              out_valid_reg;
    hight_pkg::block_t out_data_reg;
    logic              skid_valid_reg;
    hight_pkg::block_t skid_data_reg;
    logic              push;
    logic              pop;

    assign pipe_en  = !skid_valid_reg;
    assign push     = pipe_en && valid_reg[STAGES-1];
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || pop) begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : out_data;
        end else if (push) begin
            skid_data_reg <= out_data;
        end
    end

endmodule

@@ tb/tb_hight_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the HIGHT block cipher top level
// Drives random and directed encrypt and decrypt items through the stream
// ports and random stalls on both sides. The key registers are reprogrammed
// between phases. Every result is checked against an independent
// HIGHT-64/128 predictor held in a small scoreboard.
// ----------------------------------------------------------------------------

// Holds the key copy, the predictor and the queue of expected result blocks.
class hight_scoreboard;

    hight_pkg::block_t   key_low;
    hight_pkg::block_t   key_high;
    hight_pkg::byte_t    delta [128];
    hight_pkg::byte_t    whiten [8];
    hight_pkg::byte_t    round_key [128];
    hight_pkg::block_t   expected_blocks [$];
    int                  mismatches;

    function new();
        logic [6:0] lfsr;
        lfsr = 7'h5A;
        for (int i = 0; i < 128; i++) begin
            delta[i] = {1'b0, lfsr};
            lfsr = {lfsr[0] ^ lfsr[3], lfsr[6:1]};
        end
        key_low    = '0;
        key_high   = '0;
        mismatches = 0;
        expand_keys();
    endfunction

    function hight_pkg::byte_t rotl(hight_pkg::byte_t x, int n);
        logic [15:0] wide;
        wide = {x, x} << n;
        return wide[15:8];
    endfunction

    function hight_pkg::byte_t f0(hight_pkg::byte_t x);
        return rotl(x, 1) ^ rotl(x, 2) ^ rotl(x, 7);
    endfunction

    function hight_pkg::byte_t f1(hight_pkg::byte_t x);
        return rotl(x, 3) ^ rotl(x, 4) ^ rotl(x, 6);
    endfunction

    // Whitening bytes and the 128 round key bytes from the current master key.
    function void expand_keys();
        hight_pkg::byte_t mk [16];
        int m;
        for (int i = 0; i < 8; i++) begin
            mk[i]     = key_low[8*i +: 8];
            mk[i + 8] = key_high[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            whiten[i]     = mk[i + 12];
            whiten[i + 4] = mk[i];
        end
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                m = (j - i) & 7;
                round_key[16*i + j]     = mk[m] + delta[16*i + j];
                round_key[16*i + j + 8] = mk[m + 8] + delta[16*i + j + 8];
            end
        end
    endfunction

    function void set_key_reg(logic index, hight_pkg::block_t value);
        if (index == hight_pkg::REG_KEY_LOW) begin
            key_low = value;
        end else begin
            key_high = value;
        end
        expand_keys();
    endfunction

    // Full 32-round HIGHT encryption or decryption of one block.
    function hight_pkg::block_t cipher_block(logic mode, hight_pkg::block_t blk);
        hight_pkg::byte_t x [8];
        hight_pkg::byte_t y [8];
        hight_pkg::block_t res;
        for (int i = 0; i < 8; i++) begin
            x[i] = blk[8*i +: 8];
        end
        if (mode == hight_pkg::MODE_DEC) begin
            x[0] = x[0] - whiten[4];
            x[2] = x[2] ^ whiten[5];
            x[4] = x[4] - whiten[6];
            x[6] = x[6] ^ whiten[7];
            x[1] = x[1] - (f1(x[0]) ^ round_key[124]);
            x[3] = x[3] ^ (f0(x[2]) + round_key[125]);
            x[5] = x[5] - (f1(x[4]) ^ round_key[126]);
            x[7] = x[7] ^ (f0(x[6]) + round_key[127]);
            for (int r = 30; r >= 0; r--) begin
                y[0] = x[1];
                y[2] = x[3];
                y[4] = x[5];
                y[6] = x[7];
                y[7] = x[0] ^ (f0(y[6]) + round_key[4*r + 3]);
                y[1] = x[2] - (f1(y[0]) ^ round_key[4*r]);
                y[3] = x[4] ^ (f0(y[2]) + round_key[4*r + 1]);
                y[5] = x[6] - (f1(y[4]) ^ round_key[4*r + 2]);
                x = y;
            end
            x[0] = x[0] - whiten[0];
            x[2] = x[2] ^ whiten[1];
            x[4] = x[4] - whiten[2];
            x[6] = x[6] ^ whiten[3];
        end else begin
            x[0] = x[0] + whiten[0];
            x[2] = x[2] ^ whiten[1];
            x[4] = x[4] + whiten[2];
            x[6] = x[6] ^ whiten[3];
            for (int r = 0; r < 31; r++) begin
                y[1] = x[0];
                y[3] = x[2];
                y[5] = x[4];
                y[7] = x[6];
                y[0] = x[7] ^ (f0(x[6]) + round_key[4*r + 3]);
                y[2] = x[1] + (f1(x[0]) ^ round_key[4*r]);
                y[4] = x[3] ^ (f0(x[2]) + round_key[4*r + 1]);
                y[6] = x[5] + (f1(x[4]) ^ round_key[4*r + 2]);
                x = y;
            end
            x[1] = x[1] + (f1(x[0]) ^ round_key[124]);
            x[3] = x[3] ^ (f0(x[2]) + round_key[125]);
            x[5] = x[5] + (f1(x[4]) ^ round_key[126]);
            x[7] = x[7] ^ (f0(x[6]) + round_key[127]);
            x[0] = x[0] + whiten[4];
            x[2] = x[2] ^ whiten[5];
            x[4] = x[4] + whiten[6];
            x[6] = x[6] ^ whiten[7];
        end
        for (int i = 0; i < 8; i++) begin
            res[8*i +: 8] = x[i];
        end
        return res;
    endfunction

    function void note_block(logic mode, hight_pkg::block_t blk);
        expected_blocks.push_back(cipher_block(mode, blk));
    endfunction

    function void check_block(hight_pkg::block_t got);
        hight_pkg::block_t want;
        if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result block %h", got);
            end
            return;
        end
        want = expected_blocks.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("block_out mismatch: expected %h, got %h", want, got);
            end
        end
    endfunction

    function int outstanding();
        return expected_blocks.size();
    endfunction

endclass

module tb_hight_block_cipher_top;

    // Random items per key setting; seven settings give about 1900 items.
    localparam int PHASE_ITEMS = 270;
    // Long enough to cover anything still in flight in the pipeline.
    localparam int SETTLE_CYCLES = 40;
    // Watchdog limit on the length of the whole run.
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] block_in
    logic        s_tuser;   // [0] mode: 0 encrypt, 1 decrypt
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] block_out

    hight_scoreboard cipher_sb;
    int              cycle_count = 0;
    bit              send_steady;
    bit              take_steady = 1'b0;

    hight_block_cipher_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one item after a random gap and holds it until it is accepted.
    // Called and returns at a falling edge; s_tvalid stays high afterwards so
    // back-to-back items need no second assignment in one time step.
    task automatic send_item(logic mode, hight_pkg::block_t blk);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            send_steady = !send_steady;
        end
        gap = send_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        // The item is taken at this edge with the key that is programmed now.
        cipher_sb.note_block(mode, blk);
        @(negedge aclk);
    endtask

    // Writes one key register while the pipeline is empty.
    task automatic program_key(logic index, hight_pkg::block_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cipher_sb.set_key_reg(index, value);
        @(negedge aclk);
    endtask

    // Stops offering items and waits until every result is back and the
    // pipeline has had time to flush.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cipher_sb.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random items, with a sprinkling of corner blocks and of round trips
    // (a block that the opposite operation under the same key just produced).
    task automatic random_items(int count);
        logic              mode;
        hight_pkg::block_t blk;
        for (int n = 0; n < count; n++) begin
            mode = 1'($urandom_range(0, 1));
            blk  = {$urandom, $urandom};
            case ($urandom_range(0, 15))
                0: begin
                    blk = '0;
                end
                1: begin
                    blk = '1;
                end
                2, 3: begin
                    blk = cipher_sb.cipher_block(
                        (mode == hight_pkg::MODE_DEC) ? hight_pkg::MODE_ENC
                                                      : hight_pkg::MODE_DEC, blk);
                end
                default: begin
                end
            endcase
            send_item(mode, blk);
        end
    endtask

    // Result side: random back-pressure per item, checked at the accepting edge.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                take_steady = !take_steady;
            end
            gap = take_steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            cipher_sb.check_block(m_tdata);
            @(negedge aclk);
        end
    end

    initial begin
        hight_pkg::block_t corner [6];
        cipher_sb   = new();
        send_steady = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = hight_pkg::REG_KEY_LOW;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = hight_pkg::MODE_ENC;
        corner = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};

        // Hold reset low, then release it at a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The all-zero key left by reset: corner blocks in both directions,
        // then round trips that must return the original plaintext.
        foreach (corner[i]) begin
            send_item(hight_pkg::MODE_ENC, corner[i]);
            send_item(hight_pkg::MODE_DEC, corner[i]);
        end
        send_item(hight_pkg::MODE_DEC,
                  cipher_sb.cipher_block(hight_pkg::MODE_ENC, 64'h0123_4567_89AB_CDEF));
        send_item(hight_pkg::MODE_ENC,
                  cipher_sb.cipher_block(hight_pkg::MODE_DEC, 64'hFEDC_BA98_7654_3210));
        random_items(PHASE_ITEMS);
        settle();

        // All-ones key.
        program_key(hight_pkg::REG_KEY_LOW, '1);
        program_key(hight_pkg::REG_KEY_HIGH, '1);
        send_item(hight_pkg::MODE_ENC, '0);
        send_item(hight_pkg::MODE_DEC, '0);
        send_item(hight_pkg::MODE_ENC, '1);
        send_item(hight_pkg::MODE_DEC, '1);
        random_items(PHASE_ITEMS);
        settle();

        // Key bytes 00, 11, ... FF with the matching plaintext pattern.
        program_key(hight_pkg::REG_KEY_LOW, 64'h7766_5544_3322_1100);
        program_key(hight_pkg::REG_KEY_HIGH, 64'hFFEE_DDCC_BBAA_9988);
        send_item(hight_pkg::MODE_ENC, 64'h7766_5544_3322_1100);
        send_item(hight_pkg::MODE_DEC, 64'h7766_5544_3322_1100);
        random_items(PHASE_ITEMS);
        settle();

        // Only one half changes at a time: the other must keep its value.
        program_key(hight_pkg::REG_KEY_LOW, {$urandom, $urandom});
        random_items(PHASE_ITEMS);
        settle();

        program_key(hight_pkg::REG_KEY_HIGH, '0);
        random_items(PHASE_ITEMS);
        settle();

        program_key(hight_pkg::REG_KEY_LOW, {$urandom, $urandom});
        program_key(hight_pkg::REG_KEY_HIGH, {$urandom, $urandom});
        random_items(PHASE_ITEMS);
        settle();

        // Mixed extremes: zero low half, all-ones high half.
        program_key(hight_pkg::REG_KEY_LOW, '0);
        program_key(hight_pkg::REG_KEY_HIGH, '1);
        random_items(PHASE_ITEMS);
        settle();

        if (cipher_sb.mismatches == 0 && cipher_sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            if (cipher_sb.outstanding() != 0) begin
                $display("%0d expected result blocks never arrived",
                         cipher_sb.outstanding());
            end
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/hight_pkg.sv
rtl/hight_round.sv
rtl/hight_block_cipher_top.sv
tb/tb_hight_block_cipher_top.sv
